### src/i2cm_pkg.sv
// Shared types and constants for the I2C master register transfer block.
package i2cm_pkg;

    localparam int MAX_BYTES_DEF = 16;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd54;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_LOAD    = 2'd1,
        MODE_START_W = 2'd2,
        MODE_START_R = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ADDR_W = 2'd0,
        KIND_REG    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ADDR_R = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0] mode;
        logic       sda_in;
        logic [7:0] write_data;
        logic [7:0] reg_address;
        logic [4:0] transfer_length;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       busy_res;
        logic       done_res;
    } t_result;

endpackage

### src/i2cm_core.sv
// Bus phase sequencer, write buffer and device address register.
module i2cm_core #(
    parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  i2cm_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data,
    output i2cm_pkg::t_result o_result
);
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LW = (CW > 5) ? CW : 5;

    typedef enum logic [17:0] {
        ST_IDLE = 18'b000000000000000001,
        ST_S1   = 18'b000000000000000010,
        ST_S2   = 18'b000000000000000100,
        ST_S3   = 18'b000000000000001000,
        ST_TX0  = 18'b000000000000010000,
        ST_TX1  = 18'b000000000000100000,
        ST_TX2  = 18'b000000000001000000,
        ST_TX3  = 18'b000000000010000000,
        ST_RX0  = 18'b000000000100000000,
        ST_RX1  = 18'b000000001000000000,
        ST_RX2  = 18'b000000010000000000,
        ST_RX3  = 18'b000000100000000000,
        ST_P1   = 18'b000001000000000000,
        ST_P2   = 18'b000010000000000000,
        ST_P3   = 18'b000100000000000000,
        ST_R1   = 18'b001000000000000000,
        ST_R2   = 18'b010000000000000000,
        ST_R3   = 18'b100000000000000000
    } t_state;

    t_state              r_state, n_state;
    i2cm_pkg::t_kind     r_kind, n_kind;
    logic [3:0]          r_bit_count, n_bit_count;
    logic [CW-1:0]       r_byte_count, n_byte_count;
    logic [7:0]          r_shift, n_shift;
    logic [CW-1:0]       r_fill, n_fill;
    logic [7:0]          r_held_reg, n_held_reg;
    logic [CW-1:0]       r_held_len, n_held_len;
    logic                r_is_read, n_is_read;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;
    logic [6:0]          r_dev_addr;

    logic [7:0]          r_buf [0:MAX_BYTES-1];
    logic [7:0]          r_rd_byte;
    logic [AW-1:0]       rd_addr;
    logic                buf_we;

    logic [CW-1:0]       byte_next;
    logic [3:0]          bit_next;
    logic                nack;
    logic [LW-1:0]       len_ext;
    logic [LW-1:0]       max_ext;
    logic [CW-1:0]       len_sat;
    logic [7:0]          rx_byte;
    logic [7:0]          rdata;
    logic                rvalid;
    logic                done;

    assign byte_next = r_byte_count + CW'(1);
    assign bit_next  = r_bit_count + 4'd1;
    assign nack      = (byte_next >= r_held_len);
    assign len_ext   = LW'(i_item.transfer_length);
    assign max_ext   = LW'(MAX_BYTES);
    assign len_sat   = (len_ext > max_ext) ? max_ext[CW-1:0] : len_ext[CW-1:0];
    assign rx_byte   = {r_shift[6:0], i_item.sda_in};

    // The next data byte is prefetched: its address is stable throughout the byte
    // before the acknowledge phase that loads it into the shifter.
    assign rd_addr = (r_kind == i2cm_pkg::KIND_DATA) ? AW'(byte_next) : '0;

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[r_fill[AW-1:0]] <= i_item.write_data;
        end
        r_rd_byte <= r_buf[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_bit_count  = r_bit_count;
        n_byte_count = r_byte_count;
        n_shift      = r_shift;
        n_fill       = r_fill;
        n_held_reg   = r_held_reg;
        n_held_len   = r_held_len;
        n_is_read    = r_is_read;
        n_scl        = r_scl;
        n_sda        = r_sda;
        buf_we       = 1'b0;
        rdata        = 8'd0;
        rvalid       = 1'b0;
        done         = 1'b0;

        if (i_fire) begin
            if (r_state == ST_IDLE) begin
                unique case (i2cm_pkg::t_mode'(i_item.mode))
                    i2cm_pkg::MODE_TICK: begin
                    end
                    i2cm_pkg::MODE_LOAD: begin
                        if (r_fill < CW'(MAX_BYTES)) begin
                            buf_we = 1'b1;
                            n_fill = r_fill + CW'(1);
                        end
                    end
                    i2cm_pkg::MODE_START_W, i2cm_pkg::MODE_START_R: begin
                        n_held_reg   = i_item.reg_address;
                        n_held_len   = len_sat;
                        n_is_read    = (i_item.mode == i2cm_pkg::MODE_START_R);
                        n_byte_count = '0;
                        n_bit_count  = 4'd0;
                        if (i_item.mode == i2cm_pkg::MODE_START_W) begin
                            n_fill = '0;
                        end
                        n_state = ST_S1;
                    end
                    default: begin
                    end
                endcase
            end else if (i_item.mode == i2cm_pkg::MODE_TICK) begin
                unique case (r_state)
                    ST_S1, ST_R1: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        n_state = (r_state == ST_S1) ? ST_S2 : ST_R2;
                    end
                    ST_S2, ST_R2: begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                        n_state = (r_state == ST_S2) ? ST_S3 : ST_R3;
                    end
                    ST_S3: begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                        n_kind = i2cm_pkg::KIND_ADDR_W;
                        n_shift = {r_dev_addr, 1'b0};
                        n_bit_count = 4'd0;
                        n_state = ST_TX0;
                    end
                    ST_R3: begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                        n_kind = i2cm_pkg::KIND_ADDR_R;
                        n_shift = {r_dev_addr, 1'b1};
                        n_bit_count = 4'd0;
                        n_state = ST_TX0;
                    end
                    ST_TX0: begin
                        n_scl = 1'b1;
                        n_sda = r_shift[7];
                        n_state = ST_TX1;
                    end
                    ST_TX1: begin
                        n_scl = 1'b0;
                        n_sda = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit_count = bit_next;
                        n_state = (bit_next >= 4'd8) ? ST_TX2 : ST_TX0;
                    end
                    ST_TX2: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        n_state = ST_TX3;
                    end
                    ST_TX3: begin
                        n_scl = 1'b0;
                        n_sda = 1'b1;
                        unique case (r_kind)
                            i2cm_pkg::KIND_ADDR_W: begin
                                n_kind = i2cm_pkg::KIND_REG;
                                n_shift = r_held_reg;
                                n_bit_count = 4'd0;
                                n_state = ST_TX0;
                            end
                            i2cm_pkg::KIND_REG: begin
                                if (r_is_read) begin
                                    n_state = ST_R1;
                                end else if (r_held_len != '0) begin
                                    n_byte_count = '0;
                                    n_kind = i2cm_pkg::KIND_DATA;
                                    n_shift = r_rd_byte;
                                    n_bit_count = 4'd0;
                                    n_state = ST_TX0;
                                end else begin
                                    n_state = ST_P1;
                                end
                            end
                            i2cm_pkg::KIND_DATA: begin
                                n_byte_count = byte_next;
                                if (byte_next < r_held_len) begin
                                    n_shift = r_rd_byte;
                                    n_bit_count = 4'd0;
                                    n_state = ST_TX0;
                                end else begin
                                    n_state = ST_P1;
                                end
                            end
                            i2cm_pkg::KIND_ADDR_R: begin
                                n_byte_count = '0;
                                if (r_held_len != '0) begin
                                    n_shift = 8'd0;
                                    n_bit_count = 4'd0;
                                    n_state = ST_RX0;
                                end else begin
                                    n_state = ST_P1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    ST_RX0: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        n_state = ST_RX1;
                    end
                    ST_RX1: begin
                        n_scl = 1'b0;
                        n_sda = 1'b1;
                        n_shift = rx_byte;
                        n_bit_count = bit_next;
                        if (bit_next >= 4'd8) begin
                            rdata = rx_byte;
                            rvalid = 1'b1;
                            n_state = ST_RX2;
                        end else begin
                            n_state = ST_RX0;
                        end
                    end
                    ST_RX2: begin
                        n_scl = 1'b1;
                        n_sda = nack;
                        n_state = ST_RX3;
                    end
                    ST_RX3: begin
                        n_scl = 1'b0;
                        n_sda = nack;
                        n_byte_count = byte_next;
                        if (byte_next < r_held_len) begin
                            n_shift = 8'd0;
                            n_bit_count = 4'd0;
                            n_state = ST_RX0;
                        end else begin
                            n_state = ST_P1;
                        end
                    end
                    ST_P1: begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                        n_state = ST_P2;
                    end
                    ST_P2: begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                        n_state = ST_P3;
                    end
                    ST_P3: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        done = 1'b1;
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_kind       <= i2cm_pkg::KIND_ADDR_W;
            r_bit_count  <= 4'd0;
            r_byte_count <= '0;
            r_shift      <= 8'd0;
            r_fill       <= '0;
            r_held_reg   <= 8'd0;
            r_held_len   <= '0;
            r_is_read    <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_dev_addr   <= i2cm_pkg::DEV_ADDR_RESET;
        end else begin
            r_state      <= n_state;
            r_kind       <= n_kind;
            r_bit_count  <= n_bit_count;
            r_byte_count <= n_byte_count;
            r_shift      <= n_shift;
            r_fill       <= n_fill;
            r_held_reg   <= n_held_reg;
            r_held_len   <= n_held_len;
            r_is_read    <= n_is_read;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_data;
            end
        end
    end

    always_comb begin
        o_result.scl        = n_scl;
        o_result.sda_out    = n_sda;
        o_result.read_data  = rdata;
        o_result.read_valid = rvalid;
        o_result.busy_res   = (n_state != ST_IDLE);
        o_result.done_res   = done;
    end

endmodule

### src/i2cm_out_reg.sv
// Result register that holds one beat until the consumer takes it.
module i2cm_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2cm_pkg::t_result i_result,
    input  logic              i_load,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output i2cm_pkg::t_result o_data
);
    logic              r_valid;
    i2cm_pkg::t_result r_data;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/i2c_master_register_transfer.sv
// An item's result beat is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle while result beats are taken; the sequencer updates
// its phase in the accept cycle; the result register frees in the cycle it is taken.
// Reset (synchronous, active low): bus released, idle, buffer empty, address 54.
// Buffer contents are not cleared by reset; no clearing pass is needed.
// Top level of the I2C master register transfer block.
module i2c_master_register_transfer #(
    parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  i2cm_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output i2cm_pkg::t_result o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data
);
    logic              in_fire;
    logic              can_load;
    i2cm_pkg::t_result result;

    // Neither channel takes a beat while reset is held.
    assign o_in_ready  = can_load && i_rst_n;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;

    i2cm_core #(
        .MAX_BYTES(MAX_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_item     (i_in_data),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    i2cm_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .i_load     (in_fire),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

### src/i2cm_chk.sv
// Port-level checker for the I2C master register transfer block, with its bind.
module i2cm_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input i2cm_pkg::t_result o_out_data
);

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // The beat that finishes the stop condition leaves the bus idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res
            && o_out_data.scl && o_out_data.sda_out)
        else $error("done without released bus and idle");

    // A received byte completes on the low half of a clock with SDA released.
    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_valid |-> o_out_data.busy_res
            && !o_out_data.scl && o_out_data.sda_out)
        else $error("read byte outside a receive clock");

    // Read data stays zero unless a byte completes.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.read_valid |-> o_out_data.read_data == 8'd0)
        else $error("read data without read valid");

endmodule

bind i2c_master_register_transfer i2cm_chk u_chk (.*);
